/* src/xst_pkg.sv */
// Shared types and constants for the XOR segment tree.
`default_nettype none
package xst_pkg;

    localparam int IDX_W  = 11;   // leaf index / bound field width
    localparam int DATA_W = 64;   // word width

    typedef logic [1:0]        t_func;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_word;

    localparam t_func FUNC_SET   = 2'd0;
    localparam t_func FUNC_GET   = 2'd1;
    localparam t_func FUNC_RANGE = 2'd2;

    localparam t_idx ENTRIES_RESET = 11'd1024;

endpackage
`default_nettype wire

/* src/xst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/xor_segment_tree_core.sv */
// Top level: segment tree of 64-bit words with point set, point get and range XOR.
`default_nettype none
// The tree keeps 2**LEVELS leaves in a node store of 2*2**LEVELS words (one RAM,
// one write and one registered read port); node 1 is the root and leaf i sits at
// node 2**LEVELS + i. A transfer on the input channel carries one request and
// yields exactly one result transfer: set writes the leaf and rewrites its
// LEVELS ancestors (data 0), get returns the leaf, range returns the XOR of the
// leaves in [lo_index, hi_index). Bad indices, bad bounds and the unused
// function code return data 0 with error set and change nothing. One request
// is in flight at a time, and the single RAM read port serves its nodes one
// by one; range reads up to two nodes per level, root level included.
// The result sits in an output register, so the next request is taken while
// it waits. After reset all 2*2**LEVELS words of the node store are swept to
// zero, one word a cycle, before o_ready first rises; entries_in_use writes
// are taken during the sweep.
module xor_segment_tree_core
    import xst_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration: entries_in_use
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [IDX_W-1:0]  i_lo_index,
    input  wire logic [IDX_W-1:0]  i_hi_index,
    input  wire logic [DATA_W-1:0] i_value,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_data,
    output logic                   o_error
);

    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES;
    localparam int AW     = LEVELS + 1;                       // RAM address
    localparam int NW     = LEVELS + 2;                       // node index up to NODES
    localparam int CW     = (NW > IDX_W + 1) ? NW : IDX_W + 1; // compare width

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SET_LEAF = 3'd2;
    localparam logic [2:0] S_SET_UP   = 3'd3;
    localparam logic [2:0] S_GET      = 3'd4;
    localparam logic [2:0] S_RNG_L    = 3'd5;
    localparam logic [2:0] S_RNG_R    = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [NW-1:0]     r_l, n_l;
    logic [NW-1:0]     r_r, n_r;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_pend, n_pend;   // RAM read data lands this cycle
    t_func             r_func, n_func;
    logic              r_err, n_err;
    t_idx              r_entries;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_odata, n_odata;
    logic              r_oerr, n_oerr;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_acc;
    logic [CW-1:0]     w_bound, w_lo, w_hi, w_entries;
    logic [NW-1:0]     w_par;
    logic              w_take;

    xst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // effective leaf bound saturates at the tree size
    assign w_entries = CW'(r_entries);
    assign w_bound   = (w_entries > CW'(LEAVES)) ? CW'(LEAVES) : w_entries;
    assign w_lo      = CW'(i_lo_index);
    assign w_hi      = CW'(i_hi_index);

    // running XOR folds in the read that was issued last cycle
    assign w_acc  = r_acc ^ (r_pend ? w_rdata : '0);
    assign w_par  = r_l >> 1;
    assign w_take = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_l      = r_l;
        n_r      = r_r;
        n_acc    = w_acc;
        n_pend   = 1'b0;
        n_func   = r_func;
        n_err    = r_err;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        n_oerr   = r_oerr;
        w_we     = 1'b0;
        w_waddr  = r_l[AW-1:0];
        w_wdata  = w_acc;
        w_raddr  = r_l[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_func = i_func;
                    n_err  = 1'b0;
                    n_acc  = '0;
                    n_l    = NW'(w_lo + CW'(LEAVES));
                    n_r    = NW'(w_hi + CW'(LEAVES));
                    case (i_func)
                        FUNC_SET: begin
                            n_acc = i_value;
                            if (w_lo < w_bound) begin
                                n_state = S_SET_LEAF;
                            end else begin
                                n_acc   = '0;
                                n_err   = 1'b1;
                                n_state = S_FINISH;
                            end
                        end
                        FUNC_GET: begin
                            if (w_lo < w_bound) begin
                                n_state = S_GET;
                            end else begin
                                n_err   = 1'b1;
                                n_state = S_FINISH;
                            end
                        end
                        FUNC_RANGE: begin
                            if (w_lo <= w_hi && w_hi <= w_bound) begin
                                n_state = S_RNG_L;
                            end else begin
                                n_err   = 1'b1;
                                n_state = S_FINISH;
                            end
                        end
                        default: begin
                            n_err   = 1'b1;
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SET_LEAF: begin
                // write the leaf, fetch its sibling
                w_we    = 1'b1;
                w_waddr = r_l[AW-1:0];
                w_raddr = r_l[AW-1:0] ^ AW'(1);
                n_pend  = 1'b1;
                n_state = S_SET_UP;
            end
            S_SET_UP: begin
                // parent = own subtree XOR sibling
                w_we    = 1'b1;
                w_waddr = w_par[AW-1:0];
                w_raddr = w_par[AW-1:0] ^ AW'(1);
                n_l     = w_par;
                if (w_par == NW'(1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_pend = 1'b1;
                end
            end
            S_GET: begin
                w_raddr = r_l[AW-1:0];
                n_pend  = 1'b1;
                n_state = S_FINISH;
            end
            S_RNG_L: begin
                if (r_l >= r_r) begin
                    n_state = S_FINISH;
                end else begin
                    if (r_l[0]) begin
                        w_raddr = r_l[AW-1:0];
                        n_pend  = 1'b1;
                        n_l     = r_l + NW'(1);
                    end
                    n_state = S_RNG_R;
                end
            end
            S_RNG_R: begin
                if (r_r[0]) begin
                    w_raddr = AW'(r_r - NW'(1));
                    n_pend  = 1'b1;
                end
                // (r-1)>>1 equals r>>1 when r is odd
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_RNG_L;
            end
            S_FINISH: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = (r_func == FUNC_SET) ? '0 : w_acc;
                    n_oerr   = r_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_entries <= ENTRIES_RESET;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_entries <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l     <= n_l;
        r_r     <= n_r;
        r_acc   <= n_acc;
        r_func  <= n_func;
        r_err   <= n_err;
        r_odata <= n_odata;
        r_oerr  <= n_oerr;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_error = r_oerr;

endmodule
`default_nettype wire

/* src/xst_checker.sv */
// Port-level checker for the XOR segment tree, bound to the top level.
`default_nettype none
module xst_checker
    import xst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DATA_W-1:0] o_data,
    input wire logic              o_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data) && $stable(o_error))
        else $error("result changed while stalled");

    // one request at a time: ready drops after a transfer
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after request transfer");

    // error results carry zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_data == '0)
        else $error("error result with nonzero data");

    // reset empties the output and starts the clearing sweep
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output or ready live right after reset");

endmodule

bind xor_segment_tree_core xst_checker u_xst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data),
    .o_error (o_error)
);
`default_nettype wire

/* dv/xst_result_checker.sv */
// Result checker for the XOR segment tree: watches both channels, predicts, compares.
`default_nettype none
module xst_result_checker
    import xst_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire t_idx  i_cfg_data,
    input  wire logic  i_req_valid,
    input  wire logic  i_req_ready,
    input  wire t_func i_func,
    input  wire t_idx  i_lo_index,
    input  wire t_idx  i_hi_index,
    input  wire t_word i_value,
    input  wire logic  i_rsp_valid,
    input  wire logic  i_rsp_ready,
    input  wire t_word i_data,
    input  wire logic  i_error,
    output int         o_pending,
    output int         o_failures
);

    localparam int LEAF_COUNT = 1 << LEVELS;

    typedef struct packed {
        t_word data;
        logic  error;
    } t_answer;

    // own copy of the node store and the leaf count register
    t_word   tree_word [0:2*LEAF_COUNT-1];
    int      leaf_total;
    t_answer answer_q [$];

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
        o_failures++;
    endtask

    // XOR tree update / lookup; returns the answer the block owes for one request
    function automatic t_answer tree_request(t_func func, t_idx lo, t_idx hi, t_word value);
        t_answer ans;
        int      limit;
        int      node;
        int      l;
        int      r;
        ans   = '0;
        limit = (leaf_total > LEAF_COUNT) ? LEAF_COUNT : leaf_total;
        case (func)
            FUNC_SET: begin
                if (int'(lo) < limit) begin
                    node = int'(lo) + LEAF_COUNT;
                    tree_word[node] = value;
                    for (int i = 1; i <= LEVELS; i++) begin
                        node = node >> 1;
                        tree_word[node] = tree_word[2*node] ^ tree_word[2*node+1];
                    end
                end else begin
                    ans.error = 1'b1;
                end
            end
            FUNC_GET: begin
                if (int'(lo) < limit)
                    ans.data = tree_word[int'(lo) + LEAF_COUNT];
                else
                    ans.error = 1'b1;
            end
            FUNC_RANGE: begin
                if (lo <= hi && int'(hi) <= limit) begin
                    l = int'(lo) + LEAF_COUNT;
                    r = int'(hi) + LEAF_COUNT;
                    while (l < r) begin
                        if (l[0]) begin
                            ans.data ^= tree_word[l];
                            l++;
                        end
                        if (r[0]) begin
                            r--;
                            ans.data ^= tree_word[r];
                        end
                        l = l >> 1;
                        r = r >> 1;
                    end
                end else begin
                    ans.error = 1'b1;
                end
            end
            default: ans.error = 1'b1;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int k = 0; k < 2*LEAF_COUNT; k++)
                tree_word[k] = '0;
            leaf_total = int'(ENTRIES_RESET);
            answer_q.delete();
            o_failures = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                leaf_total = int'(i_cfg_data);
            if (i_req_valid && i_req_ready)
                answer_q.insert(answer_q.size(),
                                tree_request(i_func, i_lo_index, i_hi_index, i_value));
            if (i_rsp_valid && i_rsp_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result with no request waiting", i_data, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_data !== want.data)
                        report_mismatch("data", i_data, want.data);
                    if (i_error !== want.error)
                        report_mismatch("error", t_word'(i_error), t_word'(want.error));
                end
            end
            o_pending <= answer_q.size();
        end
    end

endmodule
`default_nettype wire

/* dv/xor_segment_tree_core_test.sv */
// Testbench top for xor_segment_tree_core: stimulus, stalls, watchdog and verdict.
`default_nettype none
module xor_segment_tree_core_test;
    import xst_pkg::*;

    // func code the block does not define; must come back as an error
    localparam t_func FUNC_UNUSED     = 2'd3;
    localparam int    LEAF_COUNT      = 1024;
    localparam int    PHASES          = 9;
    localparam int    ITEMS_PER_PHASE = 210;
    // margin after all results are back, before a register write or the verdict
    localparam int    DRAIN_CYCLES    = 40;
    // receiver hold-off used to back the block up
    localparam int    HOLD_CYCLES     = 400;
    // idle cycles allowed in a row: covers the clearing sweep,
    // the long hold-off and worst random stalls several times over
    localparam int    QUIET_LIMIT     = 20000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  cfg_we    = 1'b0;
    t_idx  cfg_data  = '0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    t_func req_func  = FUNC_SET;
    t_idx  req_lo    = '0;
    t_idx  req_hi    = '0;
    t_word req_value = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    t_word rsp_data;
    logic  rsp_error;

    int pending;
    int failures;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int leaf_bound    = LEAF_COUNT;   // effective bound the generator aims at
    int phase_counts [PHASES];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    xor_segment_tree_core #(
        .LEVELS (10)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_func     (req_func),
        .i_lo_index (req_lo),
        .i_hi_index (req_hi),
        .i_value    (req_value),
        .o_valid    (rsp_valid),
        .i_ready    (rsp_ready),
        .o_data     (rsp_data),
        .o_error    (rsp_error)
    );

    xst_result_checker #(
        .LEVELS (10)
    ) result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_func      (req_func),
        .i_lo_index  (req_lo),
        .i_hi_index  (req_hi),
        .i_value     (req_value),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_data      (rsp_data),
        .i_error     (rsp_error),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    // Result side. Random stalls at recv_idle_pct; a bump of hold_asks starts a
    // long hold-off so the output register fills and o_ready drops.
    always @(posedge clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("xor_segment_tree_core: mismatch");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer. Entered and left at a
    // rising edge with nothing yet driven in that step.
    task automatic send_request(t_func func, t_idx lo, t_idx hi, t_word value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= func;
        req_lo    <= lo;
        req_hi    <= hi;
        req_value <= value;
        do @(posedge clk); while (!req_ready);
    endtask

    // Register write only with no request outstanding: all results back, then a margin.
    task automatic write_leaf_count(t_idx count);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
        leaf_bound = (int'(count) > LEAF_COUNT) ? LEAF_COUNT : int'(count);
    endtask

    // Mostly in-bound set/get/range against the current bound; the rest is
    // noise over the whole field range, unused func code included.
    task automatic random_request();
        int    pick;
        int    span;
        t_func func;
        t_idx  lo;
        t_idx  hi;
        t_word value;
        pick  = $urandom_range(99);
        value = {$urandom, $urandom};
        case ($urandom_range(15))
            0:       value = '1;
            1:       value = '0;
            default: ;
        endcase
        hi = t_idx'($urandom_range(2047));
        if (pick >= 85) begin
            func = t_func'($urandom_range(3));
            lo   = t_idx'($urandom_range(2047));
        end else begin
            lo = (leaf_bound == 0) ? '0 : t_idx'($urandom_range(leaf_bound - 1));
            if (pick < 34) begin
                func = FUNC_SET;
            end else if (pick < 55) begin
                func = FUNC_GET;
            end else begin
                func = FUNC_RANGE;
                lo   = t_idx'($urandom_range(leaf_bound));
                if ($urandom_range(1)) begin
                    hi = t_idx'($urandom_range(leaf_bound, int'(lo)));
                end else begin
                    span = $urandom_range(8);
                    hi = (int'(lo) + span > leaf_bound) ? t_idx'(leaf_bound)
                                                        : t_idx'(int'(lo) + span);
                end
            end
        end
        send_request(func, lo, hi, value);
    endtask

    initial begin
        phase_counts = '{11'd1024, 11'd2047, 11'd1, 11'd0, 11'd300,
                         11'd1023, 11'd2, 11'd777, 11'd1};
        phase_counts[PHASES-1] = $urandom_range(LEAF_COUNT, 1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // lands during the clearing sweep, which accepts register writes
        write_leaf_count(ENTRIES_RESET);

        send_idle_pct = 8;
        recv_idle_pct = 55;

        // directed: leaf extremes, bounds, empty and reversed ranges, unused code
        send_request(FUNC_SET,    11'd0,    11'd0,    64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_SET,    11'd1023, 11'd2047, 64'h8000_0000_0000_0001);
        send_request(FUNC_SET,    11'd512,  11'd0,    64'hA5A5_A5A5_5A5A_5A5A);
        send_request(FUNC_GET,    11'd0,    11'd0,    64'h0);
        send_request(FUNC_GET,    11'd1023, 11'd0,    64'h0);
        send_request(FUNC_GET,    11'd1024, 11'd0,    64'h0);
        send_request(FUNC_GET,    11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_SET,    11'd1024, 11'd0,    64'h1234_5678_9ABC_DEF0);
        send_request(FUNC_RANGE,  11'd0,    11'd1024, 64'h0);
        send_request(FUNC_RANGE,  11'd0,    11'd0,    64'h0);
        send_request(FUNC_RANGE,  11'd1024, 11'd1024, 64'h0);
        send_request(FUNC_RANGE,  11'd5,    11'd3,    64'h0);
        send_request(FUNC_RANGE,  11'd0,    11'd1025, 64'h0);
        send_request(FUNC_RANGE,  11'd2047, 11'd2047, 64'h0);
        send_request(FUNC_RANGE,  11'd1,    11'd1023, 64'h0);
        send_request(FUNC_UNUSED, 11'd0,    11'd1024, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_SET,    11'd0,    11'd0,    64'h0);
        send_request(FUNC_RANGE,  11'd0,    11'd513,  64'h0);
        send_request(FUNC_GET,    11'd512,  11'd0,    64'h0);
        send_request(FUNC_SET,    11'd1,    11'd0,    {$urandom, $urandom});
        send_request(FUNC_RANGE,  11'd0,    11'd2,    64'h0);
        send_request(FUNC_GET,    11'd1,    11'd0,    64'h0);

        // random phases: one bound each, saturating and zero bounds included;
        // three idle patterns, sender-light, receiver-light, then none
        for (int p = 0; p < PHASES; p++) begin
            write_leaf_count(t_idx'(phase_counts[p]));
            case (p / 3)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // back-pressure with a sender that never pauses
            if (p == 7)
                hold_asks++;
            repeat (ITEMS_PER_PHASE) random_request();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("xor_segment_tree_core: match");
        else
            $display("xor_segment_tree_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
src/xst_pkg.sv
src/xst_ram.sv
src/xor_segment_tree_core.sv
src/xst_checker.sv
dv/xst_result_checker.sv
dv/xor_segment_tree_core_test.sv
